/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge once reset is released
`define GBN_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked on every clock edge, reset included
`define GBN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/gbn_pkg.sv */
package gbn_pkg;

    localparam int SEQ_W        = 3;
    localparam int SLOTS        = 8;
    localparam int MAX_SEQ      = 7;
    localparam int HANDLE_W     = 32;
    localparam int LEN_W        = 9;
    localparam int PACKET_BYTES = 256;
    localparam int SLOT_W       = HANDLE_W + LEN_W;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 64;
    localparam int KIND_W    = 3;
    localparam int ACTION_W  = 3;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_PACKET  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LINK    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FRAME   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DATA_TO = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ACK_TO  = 3'd4;

    // actions
    localparam logic [ACTION_W-1:0] ACT_NONE      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SEND_DATA = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SEND_ACK  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SEND_NAK  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DELIVER   = 3'd4;

    // received frame types
    localparam logic [1:0] RX_DATA = 2'd0;
    localparam logic [1:0] RX_ACK  = 2'd1;
    localparam logic [1:0] RX_NAK  = 2'd2;

    // ack timer commands
    localparam logic [1:0] ACMD_LEAVE = 2'd0;
    localparam logic [1:0] ACMD_START = 2'd1;
    localparam logic [1:0] ACMD_STOP  = 2'd2;

    typedef struct packed {
        logic [4:0]          pad;
        logic [LEN_W-1:0]    rx_payload_length;
        logic [HANDLE_W-1:0] rx_handle;
        logic [SEQ_W-1:0]    rx_ack;
        logic [SEQ_W-1:0]    rx_seq;
        logic [1:0]          rx_type;
        logic                rx_good;
        logic [LEN_W-1:0]    packet_length;
        logic [HANDLE_W-1:0] packet_handle;
    } gbn_in_data_t;

    typedef struct packed {
        logic [4:0]          pad;
        logic                network_enable;
        logic [1:0]          ack_timer_cmd;
        logic                start_data_timer;
        logic [SLOTS-1:0]    stop_data_timers;
        logic [LEN_W-1:0]    out_length;
        logic [HANDLE_W-1:0] out_handle;
        logic [SEQ_W-1:0]    ack;
        logic [SEQ_W-1:0]    seq;
    } gbn_out_data_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                last;
        gbn_out_data_t       data;
    } gbn_result_t;

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
        return (v > LEN_W'(PACKET_BYTES)) ? LEN_W'(PACKET_BYTES) : v;
    endfunction

endpackage

/* src/gbn_ram.sv */
module gbn_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/go_back_n_link_controller_top.sv */
// Go-Back-N link controller, 3-bit sequence numbers, send window of 7. One event
// per input transfer (kind in s_tuser); every event gives one or more result
// transfers, the final one with m_tlast. An event is taken in ST_IDLE and its
// leading result is registered in ST_LEAD; each resend after a NAK frame or a
// data timeout then follows from ST_WAIT, one read of the slot memory per cycle
// while the output is free. Up to 7 frames are resent per event, and m_tready
// low stalls the results. The slot memory holds handle and length of each
// outstanding frame and needs no clearing after reset.
`include "assert_macros.svh"

module go_back_n_link_controller_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // packet_handle, packet_length, rx_good, rx_type, rx_seq, rx_ack,
    // rx_handle, rx_payload_length, zero fill
    input  logic [gbn_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind
    input  logic [gbn_pkg::KIND_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // seq, ack, out_handle, out_length, stop_data_timers, start_data_timer,
    // ack_timer_cmd, network_enable, zero fill
    output logic [gbn_pkg::M_TDATA_W-1:0]   m_tdata,
    // action
    output logic [gbn_pkg::ACTION_W-1:0]    m_tuser,
    output logic                            m_tlast
);

    import gbn_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LEAD = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    gbn_in_data_t      item_reg, item_next;
    logic [SEQ_W-1:0]  nts_reg, nts_next;
    logic [SEQ_W-1:0]  ae_reg, ae_next;
    logic [SEQ_W-1:0]  fe_reg, fe_next;
    logic [SEQ_W-1:0]  outst_reg, outst_next;
    logic              nak_ok_reg, nak_ok_next;
    logic              link_rdy_reg, link_rdy_next;
    logic [SEQ_W-1:0]  ptr_reg, ptr_next;
    logic [SEQ_W-1:0]  cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    gbn_result_t       res_reg, res_next;

    // event outcome, valid while in ST_LEAD
    logic [SEQ_W-1:0]  n_nts, n_ae, n_fe, n_outst;
    logic              n_nak, n_link;
    logic [SEQ_W-1:0]  rs_cnt;
    logic              need_lead;
    logic              wr_slot;
    gbn_result_t       lead;
    logic [SEQ_W-1:0]  n_ack;
    logic [SLOTS-1:0]  ack_mask;
    logic              out_free;

    logic              ram_we, ram_re;
    logic [SEQ_W-1:0]  ram_raddr;
    logic [SLOT_W-1:0] ram_wdata, ram_rdata;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // acknowledgments covered by rx_ack: ack_expected .. rx_ack, if inside the window
    always_comb begin
        if (SEQ_W'(item_reg.rx_ack - ae_reg) < SEQ_W'(nts_reg - ae_reg)) begin
            n_ack = SEQ_W'(item_reg.rx_ack - ae_reg + 3'd1);
        end else begin
            n_ack = '0;
        end
        for (int i = 0; i < SLOTS; i++) begin
            ack_mask[i] = (SEQ_W'(SEQ_W'(i) - ae_reg) < n_ack);
        end
    end

    always_comb begin
        n_nts     = nts_reg;
        n_ae      = ae_reg;
        n_fe      = fe_reg;
        n_outst   = outst_reg;
        n_nak     = nak_ok_reg;
        n_link    = link_rdy_reg;
        rs_cnt    = '0;
        need_lead = 1'b1;
        wr_slot   = 1'b0;
        lead      = '0;
        case (kind_reg)
            KIND_PACKET: begin
                if (outst_reg < SEQ_W'(MAX_SEQ)) begin
                    wr_slot                    = 1'b1;
                    lead.action                = ACT_SEND_DATA;
                    lead.data.seq              = nts_reg;
                    lead.data.out_handle       = item_reg.packet_handle;
                    lead.data.out_length       = sat_len(item_reg.packet_length);
                    lead.data.start_data_timer = 1'b1;
                    lead.data.ack_timer_cmd    = ACMD_STOP;
                    n_outst                    = outst_reg + 3'd1;
                    n_nts                      = nts_reg + 3'd1;
                    n_link                     = 1'b0;
                end
            end
            KIND_LINK: begin
                n_link = 1'b1;
            end
            KIND_FRAME: begin
                if (!item_reg.rx_good) begin
                    if (nak_ok_reg) begin
                        lead.action             = ACT_SEND_NAK;
                        lead.data.ack_timer_cmd = ACMD_STOP;
                        n_nak                   = 1'b0;
                    end
                end else begin
                    if (item_reg.rx_type == RX_DATA) begin
                        if (item_reg.rx_seq == fe_reg) begin
                            lead.action             = ACT_DELIVER;
                            lead.data.out_handle    = item_reg.rx_handle;
                            lead.data.out_length    = sat_len(item_reg.rx_payload_length);
                            lead.data.ack_timer_cmd = ACMD_START;
                            n_nak                   = 1'b1;
                            n_fe                    = fe_reg + 3'd1;
                        end else if (nak_ok_reg) begin
                            lead.action             = ACT_SEND_NAK;
                            lead.data.ack_timer_cmd = ACMD_STOP;
                            n_nak                   = 1'b0;
                        end
                    end
                    n_ae    = ae_reg + n_ack;
                    n_outst = (outst_reg > n_ack) ? outst_reg - n_ack : '0;
                    lead.data.stop_data_timers = ack_mask;
                    // a nak also stops the timer of the oldest frame still out
                    if (item_reg.rx_type == RX_NAK) begin
                        lead.data.stop_data_timers[n_ae] = 1'b1;
                        rs_cnt = n_outst;
                        n_link = 1'b0;
                    end
                end
            end
            KIND_DATA_TO: begin
                n_link = 1'b0;
                if (outst_reg != '0) begin
                    need_lead = 1'b0;
                    rs_cnt    = outst_reg;
                end
            end
            KIND_ACK_TO: begin
                lead.action             = ACT_SEND_ACK;
                lead.data.ack_timer_cmd = ACMD_STOP;
            end
            default: ;
        endcase
        lead.data.ack            = n_fe - 3'd1;
        lead.data.network_enable = (n_outst < SEQ_W'(MAX_SEQ)) && n_link;
        lead.last                = (rs_cnt == '0);
    end

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        item_next     = item_reg;
        nts_next      = nts_reg;
        ae_next       = ae_reg;
        fe_next       = fe_reg;
        outst_next    = outst_reg;
        nak_ok_next   = nak_ok_reg;
        link_rdy_next = link_rdy_reg;
        ptr_next      = ptr_reg;
        cnt_next      = cnt_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = ptr_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next  = s_tuser;
                    item_next  = gbn_in_data_t'(s_tdata);
                    state_next = ST_LEAD;
                end
            end
            ST_LEAD: begin
                if (!need_lead || out_free) begin
                    nts_next      = n_nts;
                    ae_next       = n_ae;
                    fe_next       = n_fe;
                    outst_next    = n_outst;
                    nak_ok_next   = n_nak;
                    link_rdy_next = n_link;
                    ram_we        = wr_slot;
                    if (need_lead) begin
                        res_next     = lead;
                        m_valid_next = 1'b1;
                    end
                    if (rs_cnt != '0) begin
                        // resends start at the oldest unacknowledged slot
                        ram_re     = 1'b1;
                        ram_raddr  = n_ae;
                        ptr_next   = n_ae;
                        cnt_next   = rs_cnt;
                        state_next = ST_WAIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    res_next                       = '0;
                    res_next.action                = ACT_SEND_DATA;
                    res_next.data.seq              = ptr_reg;
                    res_next.data.out_handle       = ram_rdata[HANDLE_W-1:0];
                    res_next.data.out_length       = ram_rdata[SLOT_W-1:HANDLE_W];
                    res_next.data.start_data_timer = 1'b1;
                    res_next.data.ack_timer_cmd    = ACMD_STOP;
                    res_next.data.ack              = fe_reg - 3'd1;
                    res_next.data.network_enable   =
                        (outst_reg < SEQ_W'(MAX_SEQ)) && link_rdy_reg;
                    res_next.last                  = (cnt_reg == 3'd1);
                    m_valid_next                   = 1'b1;
                    ptr_next                       = ptr_reg + 3'd1;
                    cnt_next                       = cnt_reg - 3'd1;
                    if (cnt_reg == 3'd1) begin
                        state_next = ST_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = ptr_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ram_wdata = {sat_len(item_reg.packet_length), item_reg.packet_handle};

    gbn_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(SLOTS)
    ) u_slot_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (nts_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            nts_reg      <= '0;
            ae_reg       <= '0;
            fe_reg       <= '0;
            outst_reg    <= '0;
            nak_ok_reg   <= 1'b1;
            link_rdy_reg <= 1'b0;
            ptr_reg      <= '0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            nts_reg      <= nts_next;
            ae_reg       <= ae_next;
            fe_reg       <= fe_next;
            outst_reg    <= outst_next;
            nak_ok_reg   <= nak_ok_next;
            link_rdy_reg <= link_rdy_next;
            ptr_reg      <= ptr_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.action;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = res_reg.data;

    // frames outstanding always match the span of the send window
    `GBN_ASSERT(a_outst_span, aclk, aresetn, outst_reg == SEQ_W'(nts_reg - ae_reg), "outstanding count out of step with window pointers")
    `GBN_ASSERT(a_wait_cnt, aclk, aresetn, (state_reg == ST_WAIT) |-> (cnt_reg != '0), "resend phase with no frames left")
    `GBN_ASSERT(a_wait_out, aclk, aresetn, (state_reg == ST_WAIT && out_free) |=> m_valid_reg, "resend slot read but no result loaded")
    `GBN_ASSERT_ALWAYS(a_we_lead, aclk, ram_we |-> (state_reg == ST_LEAD), "slot write outside event decode")

endmodule

/* tb/sv/gbn_link_checker.sv */
`timescale 1ns / 100ps

module gbn_link_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [gbn_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [gbn_pkg::KIND_W-1:0]     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [gbn_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [gbn_pkg::ACTION_W-1:0]   m_tuser,
    input  logic                           m_tlast,
    output int                             mismatches,
    output int                             pending,
    output int                             events_seen,
    output int                             results_seen,
    output int                             resends_seen,
    output int                             deliveries_seen
);

    import gbn_pkg::*;

    // link state as the controller should hold it
    logic [SEQ_W-1:0]    tx_next;
    logic [SEQ_W-1:0]    tx_base;
    logic [SEQ_W-1:0]    rx_expected;
    int                  tx_inflight;
    logic                nak_ok;
    logic                link_up;
    logic [HANDLE_W-1:0] slot_handle_mem [SLOTS];
    logic [LEN_W-1:0]    slot_len_mem [SLOTS];

    gbn_result_t   expected_actions [$];
    gbn_result_t   burst [$];
    gbn_result_t   want;
    gbn_out_data_t got_data;

    int n_mismatch = 0;
    int n_events = 0;
    int n_results = 0;
    int n_resends = 0;
    int n_deliveries = 0;

    assign mismatches      = n_mismatch;
    assign events_seen     = n_events;
    assign results_seen    = n_results;
    assign resends_seen    = n_resends;
    assign deliveries_seen = n_deliveries;

    function automatic logic [LEN_W-1:0] cap_to_packet(input logic [LEN_W-1:0] v);
        return (v > PACKET_BYTES) ? LEN_W'(PACKET_BYTES) : v;
    endfunction

    // b lies in the circular range [a, c)
    function automatic logic in_window(input logic [SEQ_W-1:0] a, b, c);
        return (a <= b && b < c) || (c < a && a <= b) || (b < c && c < a);
    endfunction

    function automatic gbn_result_t data_frame(input logic [SEQ_W-1:0] slot);
        gbn_result_t r;
        r = '0;
        r.action                = ACT_SEND_DATA;
        r.data.seq              = slot;
        r.data.out_handle       = slot_handle_mem[slot];
        r.data.out_length       = slot_len_mem[slot];
        r.data.start_data_timer = 1'b1;
        r.data.ack_timer_cmd    = ACMD_STOP;
        return r;
    endfunction

    // go back: every outstanding frame again, oldest first
    task automatic resend_outstanding();
        logic [SEQ_W-1:0] s;
        s = tx_base;
        for (int i = 0; i < tx_inflight && burst.size() < 8; i++) begin
            burst.push_back(data_frame(s));
            n_resends++;
            s++;
        end
    endtask

    task automatic predict_event(input logic [KIND_W-1:0] kind, input gbn_in_data_t d);
        gbn_result_t r;
        logic [SLOTS-1:0] stop_mask;
        r = '0;
        stop_mask = '0;
        burst.delete();
        case (kind)
            KIND_PACKET: begin
                if (tx_inflight < MAX_SEQ) begin
                    slot_handle_mem[tx_next] = d.packet_handle;
                    slot_len_mem[tx_next]    = cap_to_packet(d.packet_length);
                    tx_inflight++;
                    burst.push_back(data_frame(tx_next));
                    tx_next++;
                    link_up = 1'b0;
                end else begin
                    burst.push_back(r);
                end
            end
            KIND_LINK: begin
                link_up = 1'b1;
                burst.push_back(r);
            end
            KIND_FRAME: begin
                if (!d.rx_good) begin
                    if (nak_ok) begin
                        r.action = ACT_SEND_NAK;
                        r.data.ack_timer_cmd = ACMD_STOP;
                        nak_ok = 1'b0;
                    end
                    burst.push_back(r);
                end else begin
                    if (d.rx_type == RX_DATA) begin
                        if (d.rx_seq == rx_expected) begin
                            r.action = ACT_DELIVER;
                            r.data.out_handle = d.rx_handle;
                            r.data.out_length = cap_to_packet(d.rx_payload_length);
                            r.data.ack_timer_cmd = ACMD_START;
                            nak_ok = 1'b1;
                            rx_expected++;
                            n_deliveries++;
                        end else if (nak_ok) begin
                            r.action = ACT_SEND_NAK;
                            r.data.ack_timer_cmd = ACMD_STOP;
                            nak_ok = 1'b0;
                        end
                    end
                    // piggybacked ack retires everything up to rx_ack
                    for (int n = 0; n < SLOTS && in_window(tx_base, d.rx_ack, tx_next); n++) begin
                        if (tx_inflight > 0)
                            tx_inflight--;
                        stop_mask[tx_base] = 1'b1;
                        tx_base++;
                    end
                    if (d.rx_type == RX_NAK)
                        stop_mask[tx_base] = 1'b1;
                    r.data.stop_data_timers = stop_mask;
                    burst.push_back(r);
                    if (d.rx_type == RX_NAK) begin
                        resend_outstanding();
                        link_up = 1'b0;
                    end
                end
            end
            KIND_DATA_TO: begin
                resend_outstanding();
                if (burst.size() == 0)
                    burst.push_back(r);
                link_up = 1'b0;
            end
            KIND_ACK_TO: begin
                r.action = ACT_SEND_ACK;
                r.data.ack_timer_cmd = ACMD_STOP;
                burst.push_back(r);
            end
            default: burst.push_back(r);
        endcase
        foreach (burst[i]) begin
            burst[i].data.ack            = rx_expected - 1'b1;
            burst[i].data.network_enable = (tx_inflight < MAX_SEQ) && link_up;
            burst[i].last                = (i == burst.size() - 1);
            expected_actions.push_back(burst[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v, got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            n_mismatch++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            tx_next     = '0;
            tx_base     = '0;
            rx_expected = '0;
            tx_inflight = 0;
            nak_ok      = 1'b1;
            link_up     = 1'b0;
            expected_actions.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_actions.size() == 0) begin
                    $error("result transfer with nothing expected: action %0d", m_tuser);
                    n_mismatch++;
                end else begin
                    want = expected_actions.pop_front();
                    got_data = gbn_out_data_t'(m_tdata);
                    check_field("action", want.action, m_tuser);
                    check_field("last", want.last, m_tlast);
                    check_field("seq", want.data.seq, got_data.seq);
                    check_field("ack", want.data.ack, got_data.ack);
                    check_field("out_handle", want.data.out_handle, got_data.out_handle);
                    check_field("out_length", want.data.out_length, got_data.out_length);
                    check_field("stop_data_timers", want.data.stop_data_timers,
                                got_data.stop_data_timers);
                    check_field("start_data_timer", want.data.start_data_timer,
                                got_data.start_data_timer);
                    check_field("ack_timer_cmd", want.data.ack_timer_cmd,
                                got_data.ack_timer_cmd);
                    check_field("network_enable", want.data.network_enable,
                                got_data.network_enable);
                end
            end
            if (s_tvalid && s_tready) begin
                n_events++;
                predict_event(s_tuser, gbn_in_data_t'(s_tdata));
            end
        end
        pending <= expected_actions.size();
    end

endmodule

/* tb/sv/go_back_n_link_controller_top_tb.sv */
`timescale 1ns / 100ps

module go_back_n_link_controller_top_tb;
    import gbn_pkg::*;

    localparam int RX_HOLD_CYCLES = 400;
    localparam int RANDOM_EVENTS  = 440;

    // codes with no name in the package
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
    localparam logic [1:0]        RX_OTHER         = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [ACTION_W-1:0]   m_tuser;
    logic                  m_tlast;

    int mismatches, pending, events_seen, results_seen, resends_seen, deliveries_seen;

    // what the far end believes about the link, to aim acks and sequence numbers
    logic [SEQ_W-1:0] tx_base = '0;
    int               tx_count = 0;
    logic [SEQ_W-1:0] rx_next = '0;

    bit calm = 1'b0;
    bit rx_hold_req = 1'b0;

    go_back_n_link_controller_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    gbn_link_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatches      (mismatches),
        .pending         (pending),
        .events_seen     (events_seen),
        .results_seen    (results_seen),
        .resends_seen    (resends_seen),
        .deliveries_seen (deliveries_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        if ($urandom_range(0, 99) < 85)
            return LEN_W'($urandom_range(0, PACKET_BYTES));
        return LEN_W'($urandom_range(PACKET_BYTES + 1, (1 << LEN_W) - 1));
    endfunction

    task automatic offer(input logic [KIND_W-1:0] kind, input gbn_in_data_t d);
        logic [SEQ_W-1:0] ack_span;
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (kind == KIND_PACKET && tx_count < MAX_SEQ)
            tx_count++;
        if (kind == KIND_FRAME && d.rx_good) begin
            ack_span = d.rx_ack - tx_base;
            if (ack_span < tx_count) begin
                tx_base = d.rx_ack + 1'b1;
                tx_count -= ack_span + 1;
            end
            if (d.rx_type == RX_DATA && d.rx_seq == rx_next)
                rx_next++;
        end
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic packet(input logic [HANDLE_W-1:0] h, input logic [LEN_W-1:0] len);
        gbn_in_data_t d;
        d = '0;
        d.packet_handle = h;
        d.packet_length = len;
        offer(KIND_PACKET, d);
    endtask

    task automatic frame(input logic good, input logic [1:0] typ,
                         input logic [SEQ_W-1:0] sq, ak,
                         input logic [HANDLE_W-1:0] h, input logic [LEN_W-1:0] len);
        gbn_in_data_t d;
        d = '0;
        d.rx_good           = good;
        d.rx_type           = typ;
        d.rx_seq            = sq;
        d.rx_ack            = ak;
        d.rx_handle         = h;
        d.rx_payload_length = len;
        offer(KIND_FRAME, d);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    // receiver side: random stalls, idle-free while calm, one long hold-off
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end else if (calm || $urandom_range(0, 2) != 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat (1 + idle_len()) @(posedge aclk);
            end
        end
    end

    initial begin
        #12_000_000;
        $display("timeout with %0d results still expected", pending);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int n_done;
        int r;
        bit paused;
        bit held;
        logic [KIND_W-1:0] kind;
        gbn_in_data_t d;

        n_done = 0;
        paused = 1'b0;
        held   = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= KIND_PACKET;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // quiet events, timeouts with an empty window
        d = '0;
        offer(KIND_DATA_TO, d);
        offer(KIND_ACK_TO, d);
        offer(KIND_SPARE_FIRST, d);
        offer(KIND_SPARE_LAST, d);
        offer(KIND_LINK, d);
        // fill the window, length extremes, then one packet too many
        packet('0, '0);
        packet('1, '1);
        packet(32'h8000_0001, LEN_W'(PACKET_BYTES));
        repeat (4) packet($urandom(), pick_len());
        packet($urandom(), pick_len());
        // corrupt frames: first one naks, second stays quiet
        frame(1'b0, RX_DATA, 3'd0, 3'd0, '0, '0);
        frame(1'b0, RX_DATA, 3'd0, 3'd0, '0, '0);
        // in-order delivery with oversize payload, then out of order
        frame(1'b1, RX_DATA, rx_next, tx_base - 1'b1, '1, '1);
        frame(1'b1, RX_DATA, rx_next + 3'd5, tx_base - 1'b1, $urandom(), pick_len());
        // nak frame on a full window gives the longest burst
        frame(1'b1, RX_NAK, 3'd0, tx_base - 1'b1, $urandom(), pick_len());
        offer(KIND_DATA_TO, d);
        // unknown frame type acks like a plain ack
        frame(1'b1, RX_OTHER, 3'd0, tx_base + 3'd2, $urandom(), pick_len());
        frame(1'b1, RX_ACK, 3'd0, tx_base + 3'd3, $urandom(), pick_len());
        offer(KIND_LINK, d);
        packet($urandom(), pick_len());

        while (n_done < RANDOM_EVENTS) begin
            if (n_done == 110 && !paused) begin
                paused = 1'b1;
                hold_until_drained();
            end
            calm = (n_done >= 180 && n_done < 250);
            if (n_done == 300 && !held) begin
                held = 1'b1;
                rx_hold_req = 1'b1;
            end
            r = $urandom_range(0, 99);
            kind = (r < 30) ? KIND_PACKET :
                   (r < 40) ? KIND_LINK :
                   (r < 80) ? KIND_FRAME :
                   (r < 88) ? KIND_DATA_TO :
                   (r < 95) ? KIND_ACK_TO :
                   KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
            d = '0;
            d.packet_handle     = $urandom();
            d.packet_length     = pick_len();
            d.rx_good           = ($urandom_range(0, 9) != 0);
            r = $urandom_range(0, 99);
            d.rx_type           = (r < 45) ? RX_DATA : (r < 80) ? RX_ACK :
                                  (r < 92) ? RX_NAK : RX_OTHER;
            d.rx_seq            = ($urandom_range(0, 9) < 8) ? rx_next :
                                  SEQ_W'($urandom_range(0, 7));
            if (tx_count > 0 && $urandom_range(0, 3) != 0)
                d.rx_ack = tx_base + SEQ_W'($urandom_range(0, tx_count - 1));
            else
                d.rx_ack = SEQ_W'($urandom_range(0, 7));
            d.rx_handle         = $urandom();
            d.rx_payload_length = pick_len();
            n_done++;
            offer(kind, d);
        end
        calm = 1'b0;

        hold_until_drained();
        repeat (20) @(posedge aclk);

        $display("run covered %0d events and %0d result transfers: %0d resends, %0d deliveries",
                 events_seen, results_seen, resends_seen, deliveries_seen);
        $display("included a %0d-cycle receiver hold-off, an idle-free stretch and a mid-run drain",
                 RX_HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
